// ===== sv/fep_pkg.sv =====
// Package for the fire cell propagator: buffer geometry, word layouts and the colour palette.
// It depends on nothing; fep_update, the top level and the testbench import it.
`default_nettype none

package fep_pkg;

    localparam int WIDTH  = 256;
    localparam int HEIGHT = 128;

    localparam int ROW_W  = 7;
    localparam int COL_W  = 8;
    localparam int LVL_W  = 6;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELLS  = WIDTH * (HEIGHT - 1);

    localparam logic [ROW_W-1:0] SRC_ROW   = ROW_W'(HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(WIDTH - 1);
    localparam logic [LVL_W-1:0] MAX_LEVEL = 6'd36;

    localparam logic KIND_PROPAGATE = 1'b0;
    localparam logic KIND_READ      = 1'b1;

    localparam logic [1:0] DECAY_SHIFT_RIGHT = 2'd0;
    localparam logic [1:0] DECAY_STAY        = 2'd1;
    localparam logic [1:0] DECAY_SHIFT_LEFT  = 2'd2;
    localparam logic [1:0] DECAY_INVALID     = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [1:0]       decay;
    } item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic             rejected;
        rgb_t             colour;
        logic [COL_W-1:0] dest_column;
        logic [LVL_W-1:0] intensity;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [LVL_W-1:0]  data;
    } wr_req_t;

    function automatic rgb_t palette(input logic [LVL_W-1:0] level);
        rgb_t c;
        case (level)
            6'd0:    c = '{red: 8'd7,   green: 8'd7,   blue: 8'd7};
            6'd1:    c = '{red: 8'd31,  green: 8'd7,   blue: 8'd7};
            6'd2:    c = '{red: 8'd47,  green: 8'd15,  blue: 8'd7};
            6'd3:    c = '{red: 8'd71,  green: 8'd15,  blue: 8'd7};
            6'd4:    c = '{red: 8'd87,  green: 8'd23,  blue: 8'd7};
            6'd5:    c = '{red: 8'd103, green: 8'd31,  blue: 8'd7};
            6'd6:    c = '{red: 8'd119, green: 8'd31,  blue: 8'd7};
            6'd7:    c = '{red: 8'd143, green: 8'd39,  blue: 8'd7};
            6'd8:    c = '{red: 8'd159, green: 8'd47,  blue: 8'd7};
            6'd9:    c = '{red: 8'd175, green: 8'd63,  blue: 8'd7};
            6'd10:   c = '{red: 8'd191, green: 8'd71,  blue: 8'd7};
            6'd11:   c = '{red: 8'd199, green: 8'd71,  blue: 8'd7};
            6'd12:   c = '{red: 8'd223, green: 8'd79,  blue: 8'd7};
            6'd13:   c = '{red: 8'd223, green: 8'd87,  blue: 8'd7};
            6'd14:   c = '{red: 8'd223, green: 8'd87,  blue: 8'd7};
            6'd15:   c = '{red: 8'd215, green: 8'd95,  blue: 8'd7};
            6'd16:   c = '{red: 8'd215, green: 8'd95,  blue: 8'd7};
            6'd17:   c = '{red: 8'd215, green: 8'd103, blue: 8'd15};
            6'd18:   c = '{red: 8'd207, green: 8'd111, blue: 8'd15};
            6'd19:   c = '{red: 8'd207, green: 8'd119, blue: 8'd15};
            6'd20:   c = '{red: 8'd207, green: 8'd127, blue: 8'd15};
            6'd21:   c = '{red: 8'd207, green: 8'd135, blue: 8'd23};
            6'd22:   c = '{red: 8'd199, green: 8'd135, blue: 8'd23};
            6'd23:   c = '{red: 8'd199, green: 8'd143, blue: 8'd23};
            6'd24:   c = '{red: 8'd199, green: 8'd151, blue: 8'd31};
            6'd25:   c = '{red: 8'd191, green: 8'd159, blue: 8'd31};
            6'd26:   c = '{red: 8'd191, green: 8'd159, blue: 8'd31};
            6'd27:   c = '{red: 8'd191, green: 8'd167, blue: 8'd39};
            6'd28:   c = '{red: 8'd191, green: 8'd167, blue: 8'd39};
            6'd29:   c = '{red: 8'd191, green: 8'd175, blue: 8'd47};
            6'd30:   c = '{red: 8'd183, green: 8'd175, blue: 8'd47};
            6'd31:   c = '{red: 8'd183, green: 8'd183, blue: 8'd47};
            6'd32:   c = '{red: 8'd183, green: 8'd183, blue: 8'd55};
            6'd33:   c = '{red: 8'd207, green: 8'd207, blue: 8'd111};
            6'd34:   c = '{red: 8'd223, green: 8'd223, blue: 8'd159};
            6'd35:   c = '{red: 8'd239, green: 8'd239, blue: 8'd199};
            6'd36:   c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fep_buffer_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the fire intensity buffer; it depends on no package.
`default_nettype none

module fep_buffer_ram #(
    parameter int DEPTH  = 32512,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/fep_update.sv =====
// Modify step of the propagator: decay, wrapped destination, rejection and palette lookup.
// Depends on fep_pkg for the word layouts and the palette function.
`default_nettype none

module fep_update (
    input  wire fep_pkg::item_t                item,
    input  wire logic [fep_pkg::LVL_W-1:0]     cell_value,
    output fep_pkg::wr_req_t                   wr_req,
    output fep_pkg::result_t                   result
);
    import fep_pkg::*;

    logic             reject;
    logic [LVL_W-1:0] level;
    logic [COL_W-1:0] dest;

    always_comb
    begin
        reject = (item.kind == KIND_PROPAGATE)
              && ((item.row >= SRC_ROW) || (item.decay == DECAY_INVALID));

        // The odd decay codes take one step off the level, never below zero.
        if (item.decay[0] && (cell_value != '0))
        begin
            level = cell_value - LVL_W'(1);
        end
        else
        begin
            level = cell_value;
        end

        case (item.decay)
            DECAY_SHIFT_RIGHT: dest = (item.column == LAST_COL) ? '0 : item.column + COL_W'(1);
            DECAY_SHIFT_LEFT:  dest = (item.column == '0) ? LAST_COL : item.column - COL_W'(1);
            default:           dest = item.column;
        endcase

        wr_req = '0;
        result = '0;
        if (item.kind == KIND_READ)
        begin
            result.intensity   = cell_value;
            result.dest_column = item.column;
            result.colour      = palette(cell_value);
        end
        else if (reject)
        begin
            result.rejected = 1'b1;
        end
        else
        begin
            wr_req.we          = 1'b1;
            wr_req.addr        = {item.row, dest};
            wr_req.data        = level;
            result.intensity   = level;
            result.dest_column = dest;
            result.colour      = palette(level);
        end
    end

endmodule

`default_nettype wire

// ===== sv/fire_effect_cell_propagator.sv =====
// Top level of the fire cell propagator: sequencer, buffer RAM, source register and output word.
// Depends on fep_pkg, fep_buffer_ram and fep_update.
`default_nettype none

// A word is taken in the idle state, which reads the cell from the synchronous buffer RAM; the
// work state applies the decay, writes the destination cell back and loads the output register,
// and stalls while the output register holds a result that is not taken. A new word is taken only
// once the last has left the work state. A result may wait in the output register while the next
// word is taken. After reset the buffer is cleared one cell a cycle, all 32512 cells, with s_tready
// low; cfg_we may write the source level at any time meanwhile. The source row reads as that level.
module fire_effect_cell_propagator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row[6:0], column[14:7], decay[16:15], zero pad
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // intensity[5:0], dest_column[13:6], red[21:14],
                                        // green[29:22], blue[37:30], zero pad
    output logic             m_tuser    // rejected
);
    import fep_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WORK  = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [LVL_W-1:0]  source_reg;
    item_t             item_reg;
    logic              src_sel_reg;
    logic              m_tvalid_reg;
    result_t           result_reg;

    item_t             in_item;
    logic              accept;
    logic              advance;
    logic [ROW_W-1:0]  rd_row;
    logic [LVL_W-1:0]  rd_data;
    logic [LVL_W-1:0]  cell_value;
    wr_req_t           upd_wr;
    result_t           upd_result;
    wr_req_t           ram_wr;

    assign in_item.kind   = s_tuser;
    assign in_item.row    = s_tdata[6:0];
    assign in_item.column = s_tdata[14:7];
    assign in_item.decay  = s_tdata[16:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = (state_reg == ST_WORK) && (!m_tvalid_reg || m_tready);

    // A propagate looks at the cell one row below the one it writes.
    assign rd_row = (in_item.kind == KIND_READ) ? in_item.row : in_item.row + ROW_W'(1);

    fep_buffer_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (LVL_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (accept && (rd_row != SRC_ROW)),
        .raddr ({rd_row, in_item.column}),
        .rdata (rd_data)
    );

    assign cell_value = src_sel_reg ? source_reg : rd_data;

    fep_update u_update (
        .item       (item_reg),
        .cell_value (cell_value),
        .wr_req     (upd_wr),
        .result     (upd_result)
    );

    always_comb
    begin
        ram_wr = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = clr_addr_reg;
        end
        else if (advance)
        begin
            ram_wr = upd_wr;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            source_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                source_reg <= (cfg_wdata > MAX_LEVEL) ? MAX_LEVEL : cfg_wdata;
            end
            if (advance)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= in_item;
            src_sel_reg <= (rd_row == SRC_ROW);
        end
        if (advance)
        begin
            result_reg <= upd_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg.colour.blue, result_reg.colour.green,
                       result_reg.colour.red, result_reg.dest_column, result_reg.intensity};
    assign m_tuser  = result_reg.rejected;

endmodule

`default_nettype wire

// ===== sv/fep_checker.sv =====
// Port-level checker for the fire cell propagator, attached to the top level by a bind.
// Depends only on the top level's ports.
`default_nettype none

module fep_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A refused word carries no level, column or colour.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 40'd0)
        else $error("rejected word carries data");

    // Intensities never exceed the top of the palette, and the top level is white.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[5:0] <= 6'd36
                                 && (m_tdata[5:0] != 6'd36 || m_tdata[37:14] == 24'hFFFFFF))
        else $error("intensity or colour out of range");

    // One word is in the buffer pipeline at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in consecutive cycles");

endmodule

bind fire_effect_cell_propagator fep_checker u_fep_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for fire_effect_cell_propagator: directed and random words on the input
// stream, predicted results compared field by field on the output stream.
// Depends on fep_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

    import fep_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // Predictor state: the fire buffer without the source row, and the source intensity.
    logic [LVL_W-1:0] flame_cells [CELLS];
    logic [LVL_W-1:0] source_level = '0;

    item_t   pending_words [$];
    result_t flame_expected [$];

    item_t   next_item;
    bit      have_next     = 1'b0;
    bit      word_taken    = 1'b0;
    int      tx_wait       = 0;
    bit      send_burst    = 1'b0;

    result_t want;
    bit      result_taken  = 1'b0;
    bit      recv_burst    = 1'b0;
    bit      hold_done     = 1'b0;
    int      rx_wait       = 0;
    int      long_hold     = 0;
    int      results_checked = 0;
    int      error_count   = 0;

    fire_effect_cell_propagator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic rgb_t flame_colour(input int level);
        logic [23:0] rgb;
        rgb_t c;
        case (level)
            0:       rgb = {8'd7,   8'd7,   8'd7};
            1:       rgb = {8'd31,  8'd7,   8'd7};
            2:       rgb = {8'd47,  8'd15,  8'd7};
            3:       rgb = {8'd71,  8'd15,  8'd7};
            4:       rgb = {8'd87,  8'd23,  8'd7};
            5:       rgb = {8'd103, 8'd31,  8'd7};
            6:       rgb = {8'd119, 8'd31,  8'd7};
            7:       rgb = {8'd143, 8'd39,  8'd7};
            8:       rgb = {8'd159, 8'd47,  8'd7};
            9:       rgb = {8'd175, 8'd63,  8'd7};
            10:      rgb = {8'd191, 8'd71,  8'd7};
            11:      rgb = {8'd199, 8'd71,  8'd7};
            12:      rgb = {8'd223, 8'd79,  8'd7};
            13:      rgb = {8'd223, 8'd87,  8'd7};
            14:      rgb = {8'd223, 8'd87,  8'd7};
            15:      rgb = {8'd215, 8'd95,  8'd7};
            16:      rgb = {8'd215, 8'd95,  8'd7};
            17:      rgb = {8'd215, 8'd103, 8'd15};
            18:      rgb = {8'd207, 8'd111, 8'd15};
            19:      rgb = {8'd207, 8'd119, 8'd15};
            20:      rgb = {8'd207, 8'd127, 8'd15};
            21:      rgb = {8'd207, 8'd135, 8'd23};
            22:      rgb = {8'd199, 8'd135, 8'd23};
            23:      rgb = {8'd199, 8'd143, 8'd23};
            24:      rgb = {8'd199, 8'd151, 8'd31};
            25:      rgb = {8'd191, 8'd159, 8'd31};
            26:      rgb = {8'd191, 8'd159, 8'd31};
            27:      rgb = {8'd191, 8'd167, 8'd39};
            28:      rgb = {8'd191, 8'd167, 8'd39};
            29:      rgb = {8'd191, 8'd175, 8'd47};
            30:      rgb = {8'd183, 8'd175, 8'd47};
            31:      rgb = {8'd183, 8'd183, 8'd47};
            32:      rgb = {8'd183, 8'd183, 8'd55};
            33:      rgb = {8'd207, 8'd207, 8'd111};
            34:      rgb = {8'd223, 8'd223, 8'd159};
            35:      rgb = {8'd239, 8'd239, 8'd199};
            36:      rgb = {8'd255, 8'd255, 8'd255};
            default: rgb = '0;
        endcase
        c.red   = rgb[23:16];
        c.green = rgb[15:8];
        c.blue  = rgb[7:0];
        return c;
    endfunction

    // Destination column of a propagate, wrapping at both edges.
    function automatic int shifted_column(input int column, input logic [1:0] decay);
        if (decay == DECAY_SHIFT_LEFT)
            return (column == 0) ? WIDTH - 1 : column - 1;
        else if (decay == DECAY_SHIFT_RIGHT)
            return (column + 1 >= WIDTH) ? 0 : column + 1;
        return column;
    endfunction

    function automatic int cell_level(input int row, input int column);
        if (row >= HEIGHT - 1)
            return int'(source_level);
        return int'(flame_cells[row * WIDTH + column]);
    endfunction

    // Works out the result of one accepted word and applies its write to the buffer copy.
    function automatic result_t flame_outcome(input item_t word);
        result_t res;
        int      row;
        int      column;
        int      below;
        int      level;
        int      dest;
        res    = '0;
        row    = int'(word.row);
        column = int'(word.column);
        if (word.kind == KIND_READ)
        begin
            res.dest_column = word.column;
            if (row >= HEIGHT || column >= WIDTH)
                res.rejected = 1'b1;
            else
            begin
                level         = cell_level(row, column);
                res.intensity = LVL_W'(level);
                res.colour    = flame_colour(level);
            end
            return res;
        end
        if (row >= HEIGHT - 1 || word.decay == DECAY_INVALID || column >= WIDTH)
        begin
            res.rejected = 1'b1;
            return res;
        end
        below = cell_level(row + 1, column);
        level = (word.decay[0] && below > 0) ? below - 1 : below;
        dest  = shifted_column(column, word.decay);
        flame_cells[row * WIDTH + dest] = LVL_W'(level);
        res.intensity   = LVL_W'(level);
        res.dest_column = COL_W'(dest);
        res.colour      = flame_colour(level);
        return res;
    endfunction

    task automatic queue_word(input logic kind, input int row, input int column,
                              input logic [1:0] decay);
        item_t word;
        word.kind   = kind;
        word.row    = ROW_W'(row);
        word.column = COL_W'(column);
        word.decay  = decay;
        pending_words.push_back(word);
    endtask

    function automatic int pick_column();
        if ($urandom_range(0, 2) != 0)
            return $urandom_range(0, WIDTH - 1);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return WIDTH - 2;
            default: return WIDTH - 1;
        endcase
    endfunction

    // Mostly climbing chains of propagates that follow the written cell upwards, then
    // reads near the source row, full-range noise and words that must be refused.
    task automatic queue_flame_batch(input int count);
        int         made;
        int         pick;
        int         column;
        int         row;
        int         depth;
        logic [1:0] decay;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 1)
            begin
                queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                           $urandom_range(0, 255), 2'($urandom_range(0, 3)));
                made++;
            end
            else if (pick <= 6)
            begin
                column = pick_column();
                depth  = $urandom_range(1, 8);
                row    = ($urandom_range(0, 3) == 0) ? $urandom_range(depth - 1, HEIGHT - 2)
                                                     : HEIGHT - 2;
                for (int k = 0; k < depth; k++)
                begin
                    decay = 2'($urandom_range(0, 2));
                    queue_word(KIND_PROPAGATE, row - k, column, decay);
                    column = shifted_column(column, decay);
                    made++;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        queue_word(KIND_READ, row - k, column, 2'($urandom_range(0, 3)));
                        made++;
                    end
                end
                queue_word(KIND_READ, row - depth + 1, column, 2'($urandom_range(0, 3)));
                made++;
            end
            else if (pick <= 8)
            begin
                queue_word(KIND_READ, $urandom_range(HEIGHT - 10, HEIGHT - 1), pick_column(),
                           2'($urandom_range(0, 3)));
                made++;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_word(KIND_PROPAGATE, $urandom_range(0, 127), pick_column(),
                               DECAY_INVALID);
                else
                    queue_word(KIND_PROPAGATE, SRC_ROW, pick_column(),
                               2'($urandom_range(0, 3)));
                made++;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_words.size() != 0 || have_next || s_tvalid || flame_expected.size() != 0)
            @(negedge clk);
        // Allow the block to finish any word still in its pipeline.
        repeat (8) @(negedge clk);
    endtask

    task automatic write_source(input logic [5:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        source_level = (value > MAX_LEVEL) ? MAX_LEVEL : value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Input side: the predictor runs on the word as it sits on the port when it is taken.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            flame_expected.push_back(flame_outcome('{kind: s_tuser, row: s_tdata[6:0],
                                                     column: s_tdata[14:7],
                                                     decay: s_tdata[16:15]}));
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (word_taken || !s_tvalid)
        begin
            word_taken = 1'b0;
            if (!have_next && pending_words.size() != 0)
            begin
                next_item = pending_words.pop_front();
                have_next = 1'b1;
                tx_wait   = send_burst ? 0 : $urandom_range(0, 17);
            end
            if (have_next && tx_wait == 0)
            begin
                s_tvalid  <= 1'b1;
                s_tdata   <= {7'd0, next_item.decay, next_item.column, next_item.row};
                s_tuser   <= next_item.kind;
                have_next = 1'b0;
            end
            else
            begin
                if (have_next)
                    tx_wait--;
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_taken = 1'b1;
            results_checked++;
            if (flame_expected.size() == 0)
            begin
                $display("%0t: word with nothing expected, tdata %h tuser %b", $time, m_tdata,
                         m_tuser);
                error_count++;
            end
            else
            begin
                want = flame_expected.pop_front();
                check_field("intensity", want.intensity, m_tdata[5:0]);
                check_field("dest_column", want.dest_column, m_tdata[13:6]);
                check_field("red", want.colour.red, m_tdata[21:14]);
                check_field("green", want.colour.green, m_tdata[29:22]);
                check_field("blue", want.colour.blue, m_tdata[37:30]);
                check_field("rejected", want.rejected, m_tuser);
            end
        end
    end

    always @(negedge clk)
    begin
        // One long hold-off while the sender still has plenty to offer, so the block backs up.
        if (!hold_done && results_checked >= 150 && pending_words.size() >= 20)
        begin
            long_hold = 400;
            hold_done = 1'b1;
        end
        if (result_taken)
        begin
            result_taken = 1'b0;
            rx_wait = recv_burst ? 0 : $urandom_range(0, 17);
        end
        if (long_hold > 0)
        begin
            long_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        logic [5:0] settings [8];
        settings = '{6'd0, 6'd36, 6'd37, 6'd1, 6'd20, 6'd0, 6'd35, 6'd0};
        settings[5] = 6'($urandom_range(0, 63));
        settings[7] = 6'($urandom_range(0, 63));
        foreach (flame_cells[i])
            flame_cells[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All ones saturates to the top level; the buffer clears meanwhile.
        write_source(6'd63);
        queue_word(KIND_READ, 0, 0, DECAY_SHIFT_RIGHT);
        queue_word(KIND_READ, SRC_ROW, LAST_COL, DECAY_INVALID);
        queue_word(KIND_PROPAGATE, SRC_ROW - 1, 0, DECAY_SHIFT_LEFT);
        queue_word(KIND_PROPAGATE, SRC_ROW - 1, LAST_COL, DECAY_SHIFT_RIGHT);
        queue_word(KIND_PROPAGATE, SRC_ROW - 1, 100, DECAY_STAY);
        queue_word(KIND_READ, SRC_ROW - 1, LAST_COL, DECAY_STAY);
        queue_word(KIND_READ, SRC_ROW - 1, 0, DECAY_SHIFT_LEFT);
        queue_word(KIND_READ, SRC_ROW - 1, 100, DECAY_SHIFT_RIGHT);
        queue_word(KIND_PROPAGATE, SRC_ROW - 2, LAST_COL, DECAY_STAY);
        queue_word(KIND_PROPAGATE, SRC_ROW - 3, LAST_COL, DECAY_SHIFT_RIGHT);
        queue_word(KIND_READ, SRC_ROW - 3, 0, DECAY_STAY);
        queue_word(KIND_PROPAGATE, SRC_ROW, 5, DECAY_SHIFT_RIGHT);
        queue_word(KIND_PROPAGATE, SRC_ROW, LAST_COL, DECAY_INVALID);
        queue_word(KIND_PROPAGATE, 10, 3, DECAY_INVALID);
        queue_word(KIND_PROPAGATE, 0, 0, DECAY_STAY);
        queue_word(KIND_PROPAGATE, 0, LAST_COL, DECAY_SHIFT_LEFT);
        queue_word(KIND_READ, 0, LAST_COL - 1, DECAY_STAY);
        queue_word(KIND_READ, SRC_ROW, 0, DECAY_STAY);
        queue_word(KIND_PROPAGATE, SRC_ROW - 1, 128, DECAY_STAY);
        queue_word(KIND_READ, SRC_ROW - 1, 128, DECAY_SHIFT_LEFT);
        wait_for_drain();

        // With no source the decay must stop at zero.
        write_source(6'd0);
        queue_word(KIND_PROPAGATE, SRC_ROW - 1, 7, DECAY_STAY);
        queue_word(KIND_READ, SRC_ROW - 1, 7, DECAY_SHIFT_RIGHT);
        wait_for_drain();

        foreach (settings[p])
        begin
            write_source(settings[p]);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            queue_flame_batch(56);
            wait_for_drain();
        end

        if (error_count == 0 && flame_expected.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fep_pkg.sv
sv/fep_buffer_ram.sv
sv/fep_update.sv
sv/fire_effect_cell_propagator.sv
sv/fep_checker.sv
test/testbench.sv
